### hdl/fit_strategy_segment_allocator_unit_defines.svh
// Assertion macros shared by the segment allocator RTL.
// Included by the files that carry concurrent assertions; no other dependency.
`ifndef FIT_STRATEGY_SEGMENT_ALLOCATOR_UNIT_DEFINES_SVH
`define FIT_STRATEGY_SEGMENT_ALLOCATOR_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define FSA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define FSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/fsa_pkg.sv
// Shared types, codes and defaults of the segment allocator.
// No dependencies; used by the channel interfaces, controller, datapath and top level.
`timescale 1ns / 1ps

package fsa_pkg;

  // Default sizing of the segment table and the address space.
  localparam int unsigned DEF_MAX_SEGMENTS = 64;
  localparam int unsigned DEF_ADDR_BITS    = 16;

  // Pool size register value after reset, used when ADDR_BITS is at least 16.
  localparam int unsigned POOL_RESET = 65536;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned FIT_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // Fit strategies.
  localparam logic [FIT_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [FIT_W-1:0] FIT_WORST = 2'd2;
  localparam logic [FIT_W-1:0] FIT_NEXT  = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_FIT       = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_ALREADY_FREE = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NO_SEGMENT   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_TABLE_FULL   = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_ZERO_SIZE    = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FIT_STRATEGY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE    = 2'd1;

  // Controller states.
  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_START,
    S_PICK_RD,
    S_PICK_EV,
    S_PICK_CHK,
    S_UP_CHK,
    S_UP_RD,
    S_UP_WR,
    S_TAIL_WR,
    S_ALLOC_FIN,
    S_FREE_RD,
    S_FREE_EV,
    S_FREE_CHK,
    S_FREE_WR,
    S_DN_CHK,
    S_DN_RD,
    S_DN_WR,
    S_FREE_FIN,
    S_STAT_INIT,
    S_STAT_RD,
    S_STAT_EV,
    S_OUT
  } fsa_state_e;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_LOAD,
    CMD_PICK_EV,
    CMD_PICK_CHK,
    CMD_UP_WR,
    CMD_TAIL_WR,
    CMD_ALLOC_FIN,
    CMD_FREE_EV,
    CMD_FREE_CHK,
    CMD_FREE_WR,
    CMD_DN_WR,
    CMD_FREE_FIN,
    CMD_STAT_INIT,
    CMD_STAT_EV,
    CMD_OUT
  } fsa_cmd_e;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            want_zero;
    logic            last;
    logic            pick_stop;
    logic            pick_found;
    logic            pick_full;
    logic            pick_split;
    logic            up_more;
    logic            free_stop;
    logic            free_found;
    logic            dn_more;
    logic            out_free;
  } fsa_dp_status_t;

endpackage

### hdl/fsa_channel_if.sv
// Valid/ready channel interfaces for allocator requests and results.
// Depends on fsa_pkg for code widths and default sizing.
`timescale 1ns / 1ps

interface fsa_req_if #(
  parameter int unsigned ADDR_BITS = fsa_pkg::DEF_ADDR_BITS
);
  logic                      valid;
  logic                      ready;
  logic [fsa_pkg::OP_W-1:0]  operation;
  logic [ADDR_BITS:0]        req_size;
  logic [ADDR_BITS-1:0]      req_address;

  modport source (output valid, operation, req_size, req_address, input ready);
  modport sink (input valid, operation, req_size, req_address, output ready);
endinterface

interface fsa_rsp_if #(
  parameter int unsigned ADDR_BITS    = fsa_pkg::DEF_ADDR_BITS,
  parameter int unsigned MAX_SEGMENTS = fsa_pkg::DEF_MAX_SEGMENTS
);
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);

  logic                          valid;
  logic                          ready;
  logic [fsa_pkg::STATUS_W-1:0]  status;
  logic [ADDR_BITS-1:0]          granted_address;
  logic                          is_allocated;
  logic [CNT_W-1:0]              hole_count;
  logic [ADDR_BITS:0]            allocated_bytes;
  logic [ADDR_BITS:0]            free_bytes;
  logic [ADDR_BITS:0]            largest_free;
  logic [CNT_W-1:0]              small_free_count;

  modport source (output valid, status, granted_address, is_allocated, hole_count,
                  allocated_bytes, free_bytes, largest_free, small_free_count,
                  input ready);
  modport sink (input valid, status, granted_address, is_allocated, hole_count,
                allocated_bytes, free_bytes, largest_free, small_free_count,
                output ready);
endinterface

### hdl/fsa_ctrl.sv
// Sequencing state machine of the segment allocator.
// Depends on fsa_pkg; drives fsa_dpath through commands and reads its status.
`timescale 1ns / 1ps

module fsa_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  output logic                    req_ready_o,
  input  fsa_pkg::fsa_dp_status_t dp_status_i,
  output fsa_pkg::fsa_cmd_e       cmd_o
);
  import fsa_pkg::*;

  fsa_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT:      state_d = S_IDLE;
      S_IDLE:      if (req_valid_i) state_d = S_START;
      S_START: begin
        case (dp_status_i.op)
          OP_ALLOC: state_d = dp_status_i.want_zero ? S_STAT_INIT : S_PICK_RD;
          OP_FREE:  state_d = S_FREE_RD;
          default:  state_d = S_STAT_INIT;
        endcase
      end
      S_PICK_RD:   state_d = S_PICK_EV;
      S_PICK_EV: begin
        state_d = (dp_status_i.pick_stop || dp_status_i.last) ? S_PICK_CHK : S_PICK_RD;
      end
      S_PICK_CHK: begin
        if (!dp_status_i.pick_found || dp_status_i.pick_full) begin
          state_d = S_STAT_INIT;
        end else if (dp_status_i.pick_split) begin
          state_d = S_UP_CHK;
        end else begin
          state_d = S_ALLOC_FIN;
        end
      end
      S_UP_CHK:    state_d = dp_status_i.up_more ? S_UP_RD : S_TAIL_WR;
      S_UP_RD:     state_d = S_UP_WR;
      S_UP_WR:     state_d = S_UP_CHK;
      S_TAIL_WR:   state_d = S_ALLOC_FIN;
      S_ALLOC_FIN: state_d = S_STAT_INIT;
      S_FREE_RD:   state_d = S_FREE_EV;
      S_FREE_EV: begin
        state_d = (dp_status_i.free_stop || dp_status_i.last) ? S_FREE_CHK : S_FREE_RD;
      end
      S_FREE_CHK:  state_d = dp_status_i.free_found ? S_FREE_WR : S_STAT_INIT;
      S_FREE_WR:   state_d = S_DN_CHK;
      S_DN_CHK:    state_d = dp_status_i.dn_more ? S_DN_RD : S_FREE_FIN;
      S_DN_RD:     state_d = S_DN_WR;
      S_DN_WR:     state_d = S_DN_CHK;
      S_FREE_FIN:  state_d = S_STAT_INIT;
      S_STAT_INIT: state_d = S_STAT_RD;
      S_STAT_RD:   state_d = S_STAT_EV;
      S_STAT_EV:   state_d = dp_status_i.last ? S_OUT : S_STAT_RD;
      S_OUT:       if (dp_status_i.out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Command and handshake outputs.
  always_comb begin
    cmd_o       = CMD_NONE;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_INIT:      cmd_o = CMD_INIT;
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) cmd_o = CMD_LOAD;
      end
      S_PICK_EV:   cmd_o = CMD_PICK_EV;
      S_PICK_CHK:  cmd_o = CMD_PICK_CHK;
      S_UP_WR:     cmd_o = CMD_UP_WR;
      S_TAIL_WR:   cmd_o = CMD_TAIL_WR;
      S_ALLOC_FIN: cmd_o = CMD_ALLOC_FIN;
      S_FREE_EV:   cmd_o = CMD_FREE_EV;
      S_FREE_CHK:  cmd_o = CMD_FREE_CHK;
      S_FREE_WR:   cmd_o = CMD_FREE_WR;
      S_DN_WR:     cmd_o = CMD_DN_WR;
      S_FREE_FIN:  cmd_o = CMD_FREE_FIN;
      S_STAT_INIT: cmd_o = CMD_STAT_INIT;
      S_STAT_EV:   cmd_o = CMD_STAT_EV;
      S_OUT:       if (dp_status_i.out_free) cmd_o = CMD_OUT;
      default:     cmd_o = CMD_NONE;
    endcase
  end

endmodule

### hdl/fsa_dpath.sv
// Datapath of the segment allocator: segment table memory, scan registers,
// statistics accumulators, configuration registers and the result register.
// Depends on fsa_pkg and the assertion macros; driven by fsa_ctrl commands.
`timescale 1ns / 1ps
`include "fit_strategy_segment_allocator_unit_defines.svh"

module fsa_dpath #(
  parameter int unsigned MAX_SEGMENTS = fsa_pkg::DEF_MAX_SEGMENTS,
  parameter int unsigned ADDR_BITS    = fsa_pkg::DEF_ADDR_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fsa_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ADDR_BITS:0]                   cfg_data_i,
  input  fsa_pkg::fsa_cmd_e                    cmd_i,
  input  logic [fsa_pkg::OP_W-1:0]             in_op_i,
  input  logic [ADDR_BITS:0]                   in_size_i,
  input  logic [ADDR_BITS-1:0]                 in_addr_i,
  output fsa_pkg::fsa_dp_status_t              dp_status_o,
  output logic                                 rsp_valid_o,
  input  logic                                 rsp_ready_i,
  output logic [fsa_pkg::STATUS_W-1:0]         rsp_status_o,
  output logic [ADDR_BITS-1:0]                 rsp_granted_o,
  output logic                                 rsp_is_alloc_o,
  output logic [$clog2(MAX_SEGMENTS+1)-1:0]    rsp_holes_o,
  output logic [ADDR_BITS:0]                   rsp_alloc_bytes_o,
  output logic [ADDR_BITS:0]                   rsp_free_bytes_o,
  output logic [ADDR_BITS:0]                   rsp_largest_o,
  output logic [$clog2(MAX_SEGMENTS+1)-1:0]    rsp_small_o
);
  import fsa_pkg::*;

  localparam int unsigned IDX_W   = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned BYTES_W = ADDR_BITS + 1;
  localparam int unsigned WORD_W  = ADDR_BITS + BYTES_W + 1;
  localparam logic [BYTES_W-1:0] POOL_LIMIT = {1'b1, {ADDR_BITS{1'b0}}};
  localparam logic [BYTES_W-1:0] POOL_RST   =
    (ADDR_BITS >= 16) ? BYTES_W'(POOL_RESET) : POOL_LIMIT;
  localparam logic [CNT_W-1:0]   CNT_MAX    = CNT_W'(MAX_SEGMENTS);

  // Segment table: {start, size, used} per entry.
  logic [WORD_W-1:0] mem_q [MAX_SEGMENTS];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [WORD_W-1:0] mem_wd;

  // Configuration and table control.
  logic [FIT_W-1:0]   strategy_q;
  logic [BYTES_W-1:0] pool_q;
  logic [CNT_W-1:0]   count_q;
  logic [IDX_W-1:0]   cursor_q;
  logic               out_valid_q;

  // Request and scan registers.
  logic [OP_W-1:0]      op_q;
  logic [BYTES_W-1:0]   want_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [STATUS_W-1:0]  stat_q;
  logic [ADDR_BITS-1:0] granted_q;
  logic [CNT_W-1:0]     ptr_q;
  logic [CNT_W-1:0]     n_q;
  logic                 found_q;
  logic [IDX_W-1:0]     pick_idx_q;
  logic [BYTES_W-1:0]   pick_size_q;
  logic [ADDR_BITS-1:0] pick_start_q;
  logic                 run_act_q;
  logic [IDX_W-1:0]     run_idx_q;
  logic [ADDR_BITS-1:0] run_addr_q;
  logic [BYTES_W-1:0]   sum_q;
  logic [IDX_W-1:0]     e_q;

  // Statistics.
  logic [CNT_W-1:0]   holes_q;
  logic [BYTES_W-1:0] alloc_q;
  logic [BYTES_W-1:0] free_q;
  logic [BYTES_W-1:0] largest_q;
  logic [CNT_W-1:0]   small_q;
  logic               mark_q;
  logic               mark_found_q;

  // Result register.
  logic [STATUS_W-1:0]  o_stat_q;
  logic [ADDR_BITS-1:0] o_granted_q;
  logic                 o_mark_q;
  logic [CNT_W-1:0]     o_holes_q;
  logic [BYTES_W-1:0]   o_alloc_q;
  logic [BYTES_W-1:0]   o_free_q;
  logic [BYTES_W-1:0]   o_largest_q;
  logic [CNT_W-1:0]     o_small_q;

  // Fields of the entry read in the previous cycle.
  logic [ADDR_BITS-1:0] rd_start;
  logic [BYTES_W-1:0]   rd_size;
  logic                 rd_used;
  assign rd_start = rdata_q[WORD_W-1 -: ADDR_BITS];
  assign rd_size  = rdata_q[BYTES_W:1];
  assign rd_used  = rdata_q[0];

  // Pool size write, saturated to 1 .. 2^ADDR_BITS.
  logic               cfg_init;
  logic [BYTES_W-1:0] cfg_pool;
  logic [BYTES_W-1:0] init_pool;
  always_comb begin
    cfg_init = cfg_we_i && (cfg_idx_i == REG_FIT_STRATEGY || cfg_idx_i == REG_POOL_SIZE);
    if (cfg_data_i == '0) begin
      cfg_pool = BYTES_W'(1);
    end else if (cfg_data_i > POOL_LIMIT) begin
      cfg_pool = POOL_LIMIT;
    end else begin
      cfg_pool = cfg_data_i;
    end
    init_pool = (cfg_we_i && cfg_idx_i == REG_POOL_SIZE) ? cfg_pool : pool_q;
  end

  // Scan decisions on the current entry.
  logic             last;
  logic             fits;
  logic             pick_take;
  logic             first_like;
  logic [CNT_W-1:0] pick_next;
  logic             is_key;
  logic             free_eff;
  logic             split;
  logic [CNT_W-1:0] m_cnt;
  logic [CNT_W-1:0] up_dst;
  logic [CNT_W-1:0] dn_dst;
  logic [CNT_W-1:0] tail_idx;
  logic [CNT_W-1:0] gnt_next;
  logic [CNT_W-1:0] cnt_split;
  logic [IDX_W-1:0] free_cursor;
  always_comb begin
    last       = (n_q == count_q - CNT_W'(1));
    fits       = !rd_used && (rd_size >= want_q);
    first_like = (strategy_q == FIT_FIRST) || (strategy_q == FIT_NEXT);
    pick_take  = fits && (!found_q ||
                 (strategy_q == FIT_BEST  && rd_size < pick_size_q) ||
                 (strategy_q == FIT_WORST && rd_size > pick_size_q));
    if (strategy_q == FIT_NEXT && ptr_q == count_q - CNT_W'(1)) begin
      pick_next = '0;
    end else begin
      pick_next = ptr_q + CNT_W'(1);
    end
    is_key    = !found_q && (rd_start == addr_q);
    free_eff  = !rd_used || is_key;
    split     = (pick_size_q != want_q);
    m_cnt     = CNT_W'(e_q) - CNT_W'(run_idx_q);
    up_dst    = ptr_q + CNT_W'(1);
    dn_dst    = ptr_q - m_cnt;
    tail_idx  = CNT_W'(pick_idx_q) + CNT_W'(1);
    cnt_split = count_q + CNT_W'(split);
    gnt_next  = (tail_idx == cnt_split) ? '0 : tail_idx;
    // Cursor past the merged run shifts down; one inside it moves to the next entry, or wraps to 0.
    if (cursor_q > e_q) begin
      free_cursor = cursor_q - m_cnt[IDX_W-1:0];
    end else if (cursor_q > run_idx_q) begin
      free_cursor = (CNT_W'(e_q) == count_q - CNT_W'(1)) ? '0 : run_idx_q + IDX_W'(1);
    end else begin
      free_cursor = cursor_q;
    end
  end

  // Status to the controller.
  always_comb begin
    dp_status_o.op         = op_q;
    dp_status_o.want_zero  = (want_q == '0);
    dp_status_o.last       = last;
    dp_status_o.pick_stop  = fits && first_like;
    dp_status_o.pick_found = found_q;
    dp_status_o.pick_full  = split && (count_q >= CNT_MAX);
    dp_status_o.pick_split = split;
    dp_status_o.up_more    = ptr_q > CNT_W'(pick_idx_q);
    dp_status_o.free_stop  = found_q && rd_used;
    dp_status_o.free_found = found_q;
    dp_status_o.dn_more    = (m_cnt != '0) && (ptr_q < count_q);
    dp_status_o.out_free   = !out_valid_q || rsp_ready_i;
  end

  // Table write port; a configuration write takes precedence.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    if (cfg_init) begin
      mem_we = 1'b1;
      mem_wd = {{ADDR_BITS{1'b0}}, init_pool, 1'b0};
    end else begin
      case (cmd_i)
        CMD_INIT: begin
          mem_we = 1'b1;
          mem_wd = {{ADDR_BITS{1'b0}}, pool_q, 1'b0};
        end
        CMD_UP_WR: begin
          mem_we = 1'b1;
          mem_wa = up_dst[IDX_W-1:0];
          mem_wd = rdata_q;
        end
        CMD_TAIL_WR: begin
          mem_we = 1'b1;
          mem_wa = tail_idx[IDX_W-1:0];
          mem_wd = {ADDR_BITS'(pick_start_q + want_q), pick_size_q - want_q, 1'b0};
        end
        CMD_ALLOC_FIN: begin
          mem_we = 1'b1;
          mem_wa = pick_idx_q;
          mem_wd = {pick_start_q, want_q, 1'b1};
        end
        CMD_FREE_WR: begin
          mem_we = 1'b1;
          mem_wa = run_idx_q;
          mem_wd = {run_addr_q, sum_q, 1'b0};
        end
        CMD_DN_WR: begin
          mem_we = 1'b1;
          mem_wa = dn_dst[IDX_W-1:0];
          mem_wd = rdata_q;
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  // Table memory with registered read at the scan pointer.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= mem_q[ptr_q[IDX_W-1:0]];
  end

  // Configuration, table size, cursor and result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strategy_q  <= FIT_FIRST;
      pool_q      <= POOL_RST;
      count_q     <= CNT_W'(1);
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_FIT_STRATEGY) begin
        strategy_q <= cfg_data_i[FIT_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == REG_POOL_SIZE) begin
        pool_q <= cfg_pool;
      end
      if (cfg_init || cmd_i == CMD_INIT) begin
        count_q  <= CNT_W'(1);
        cursor_q <= '0;
      end else if (cmd_i == CMD_ALLOC_FIN) begin
        count_q  <= cnt_split;
        cursor_q <= gnt_next[IDX_W-1:0];
      end else if (cmd_i == CMD_FREE_WR) begin
        cursor_q <= free_cursor;
      end else if (cmd_i == CMD_FREE_FIN) begin
        count_q <= count_q - m_cnt;
      end
      if (cmd_i == CMD_OUT) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture, scans and statistics.
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        op_q      <= in_op_i;
        want_q    <= in_size_i;
        addr_q    <= in_addr_i;
        n_q       <= '0;
        found_q   <= 1'b0;
        run_act_q <= 1'b0;
        granted_q <= '0;
        if (in_op_i == OP_ALLOC && strategy_q == FIT_NEXT && CNT_W'(cursor_q) < count_q) begin
          ptr_q <= CNT_W'(cursor_q);
        end else begin
          ptr_q <= '0;
        end
        stat_q <= (in_op_i == OP_ALLOC && in_size_i == '0) ? STAT_ZERO_SIZE : STAT_OK;
      end
      CMD_PICK_EV: begin
        if (pick_take) begin
          found_q      <= 1'b1;
          pick_idx_q   <= ptr_q[IDX_W-1:0];
          pick_size_q  <= rd_size;
          pick_start_q <= rd_start;
        end
        ptr_q <= pick_next;
        n_q   <= n_q + CNT_W'(1);
      end
      CMD_PICK_CHK: begin
        if (!found_q) begin
          stat_q <= STAT_NO_FIT;
        end else if (split && count_q >= CNT_MAX) begin
          stat_q <= STAT_TABLE_FULL;
        end
        ptr_q <= count_q - CNT_W'(1);
      end
      CMD_UP_WR: begin
        ptr_q <= ptr_q - CNT_W'(1);
      end
      CMD_ALLOC_FIN: begin
        granted_q <= pick_start_q;
      end
      CMD_FREE_EV: begin
        if (!found_q) begin
          // Track the free run that will hold the freed entry.
          if (free_eff) begin
            if (run_act_q) begin
              sum_q <= sum_q + rd_size;
            end else begin
              run_idx_q  <= ptr_q[IDX_W-1:0];
              run_addr_q <= rd_start;
              sum_q      <= rd_size;
            end
            run_act_q <= 1'b1;
          end else begin
            run_act_q <= 1'b0;
          end
          if (is_key) begin
            found_q <= 1'b1;
            e_q     <= ptr_q[IDX_W-1:0];
            stat_q  <= rd_used ? STAT_OK : STAT_ALREADY_FREE;
          end
        end else if (!rd_used) begin
          sum_q <= sum_q + rd_size;
          e_q   <= ptr_q[IDX_W-1:0];
        end
        ptr_q <= ptr_q + CNT_W'(1);
        n_q   <= n_q + CNT_W'(1);
      end
      CMD_FREE_CHK: begin
        if (!found_q) begin
          stat_q <= STAT_NO_SEGMENT;
        end
      end
      CMD_FREE_WR: begin
        ptr_q <= CNT_W'(e_q) + CNT_W'(1);
      end
      CMD_DN_WR: begin
        ptr_q <= ptr_q + CNT_W'(1);
      end
      CMD_STAT_INIT: begin
        ptr_q        <= '0;
        n_q          <= '0;
        holes_q      <= '0;
        alloc_q      <= '0;
        free_q       <= '0;
        largest_q    <= '0;
        small_q      <= '0;
        mark_q       <= 1'b0;
        mark_found_q <= 1'b0;
      end
      CMD_STAT_EV: begin
        if (rd_used) begin
          alloc_q <= alloc_q + rd_size;
        end else begin
          holes_q <= holes_q + CNT_W'(1);
          free_q  <= free_q + rd_size;
          if (rd_size > largest_q) begin
            largest_q <= rd_size;
          end
          if (op_q == OP_QUERY && rd_size <= want_q) begin
            small_q <= small_q + CNT_W'(1);
          end
        end
        if (op_q == OP_QUERY && !mark_found_q && rd_start == addr_q) begin
          mark_q       <= rd_used;
          mark_found_q <= 1'b1;
        end
        ptr_q <= ptr_q + CNT_W'(1);
        n_q   <= n_q + CNT_W'(1);
      end
      CMD_OUT: begin
        o_stat_q    <= stat_q;
        o_granted_q <= granted_q;
        o_mark_q    <= mark_q;
        o_holes_q   <= holes_q;
        o_alloc_q   <= alloc_q;
        o_free_q    <= free_q;
        o_largest_q <= largest_q;
        o_small_q   <= small_q;
      end
      default: begin
        ptr_q <= ptr_q;
      end
    endcase
  end

  assign rsp_valid_o       = out_valid_q;
  assign rsp_status_o      = o_stat_q;
  assign rsp_granted_o     = o_granted_q;
  assign rsp_is_alloc_o    = o_mark_q;
  assign rsp_holes_o       = o_holes_q;
  assign rsp_alloc_bytes_o = o_alloc_q;
  assign rsp_free_bytes_o  = o_free_q;
  assign rsp_largest_o     = o_largest_q;
  assign rsp_small_o       = o_small_q;

  // The table always holds between one and MAX_SEGMENTS entries.
  `FSA_ASSERT(a_count_range, clk_i, rst_ni, (count_q != '0) && (count_q <= CNT_MAX), "segment count out of range")
  // The next-fit cursor always names a live entry.
  `FSA_ASSERT(a_cursor_live, clk_i, rst_ni, CNT_W'(cursor_q) < count_q, "next-fit cursor beyond table")
  // Writes never land past the first unused entry.
  `FSA_ASSERT(a_write_bound, clk_i, rst_ni, !mem_we || (CNT_W'(mem_wa) <= count_q), "table write beyond end")

endmodule

### hdl/fit_strategy_segment_allocator_unit.sv
// Top level of the segment allocator: controller, datapath and channel wiring.
// Depends on fsa_pkg, fsa_req_if, fsa_rsp_if, fsa_ctrl and fsa_dpath.
`timescale 1ns / 1ps

// Segment allocator with first, best, worst and next fit over an
// address-ordered table of up to MAX_SEGMENTS segments held in a memory with
// one write port and a registered read port. One request is handled at a time.
// Each table entry visited is read, then evaluated: an allocate scans the
// entries to pick a hole and moves entries up for a split, a free scans to
// locate and merge the segment and moves entries down, and every request ends
// with a statistics pass over the table. The result sits in an output
// register, so the next request is accepted while an earlier result waits.
// After reset, and after a write to either configuration register, the table
// holds one free segment covering the pool; after reset it is rebuilt in the
// S_INIT state.
module fit_strategy_segment_allocator_unit #(
  parameter int unsigned MAX_SEGMENTS = fsa_pkg::DEF_MAX_SEGMENTS,
  parameter int unsigned ADDR_BITS    = fsa_pkg::DEF_ADDR_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fsa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_BITS:0]            cfg_data_i,
  fsa_req_if.sink                       req,
  fsa_rsp_if.source                     rsp
);
  import fsa_pkg::*;

  fsa_cmd_e       cmd;
  fsa_dp_status_t dp_status;

  // Sequencer.
  fsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  // Table, scans and result register.
  fsa_dpath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_i             (cmd),
    .in_op_i           (req.operation),
    .in_size_i         (req.req_size),
    .in_addr_i         (req.req_address),
    .dp_status_o       (dp_status),
    .rsp_valid_o       (rsp.valid),
    .rsp_ready_i       (rsp.ready),
    .rsp_status_o      (rsp.status),
    .rsp_granted_o     (rsp.granted_address),
    .rsp_is_alloc_o    (rsp.is_allocated),
    .rsp_holes_o       (rsp.hole_count),
    .rsp_alloc_bytes_o (rsp.allocated_bytes),
    .rsp_free_bytes_o  (rsp.free_bytes),
    .rsp_largest_o     (rsp.largest_free),
    .rsp_small_o       (rsp.small_free_count)
  );

endmodule
